### sv/ggbl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ggbl_pkg
// shared types and constants of the geoid grid bilinear lookup
// ----------------------------------------------------------------------------
package ggbl_pkg;

    // grid shapes per datum
    localparam logic [9:0]  GRID_ROWS   = 10'd721;
    localparam logic [10:0] GRID_COLS   = 11'd1441;
    localparam logic [9:0]  COARSE_ROWS = 10'd361;
    localparam logic [10:0] COARSE_COLS = 11'd721;

    // index of the last post of each grid
    localparam logic [19:0] LAST_POST_GRID   = 20'd1038960;
    localparam logic [19:0] LAST_POST_COARSE = 20'd260280;

    // datum codes; the spare code acts as the 2008 grid
    localparam logic [1:0] DATUM_1984  = 2'd0;
    localparam logic [1:0] DATUM_1996  = 2'd1;
    localparam logic [1:0] DATUM_2008  = 2'd2;
    localparam logic [1:0] DATUM_SPARE = 2'd3;

    // beat kinds on the input stream
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // degrees with 16 fraction bits
    localparam logic signed [25:0] DEG_90  = 26'sd5898240;
    localparam logic signed [25:0] DEG_180 = 26'sd11796480;
    localparam logic signed [25:0] DEG_360 = 26'sd23592960;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_LAT_BAD    = 3'd1;
    localparam logic [2:0] ST_LON_BAD    = 3'd2;
    localparam logic [2:0] ST_NOT_LOADED = 3'd4;

    // grid address width before fitting to the store
    localparam int ADDR_W = 21;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic                     we;
        logic                     re;
        logic [ADDR_W-1:0]        addr_a;
        logic [ADDR_W-1:0]        addr_b;
        logic signed [15:0]       wdata;
    } t_mem_cmd;

    typedef struct packed {
        logic        valid;
        logic        second;
        logic [2:0]  status;
        logic [16:0] dx;
        logic [16:0] dy;
    } t_tag;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [17:0] height;
    } t_result;

endpackage
`default_nettype wire

### sv/ggbl_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ggbl_front
// position checks, cell scaling, post addressing and memory issue
// ----------------------------------------------------------------------------
module ggbl_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic               i_query,
    input  wire logic               i_wr_ok,
    input  wire logic               i_loaded,
    input  wire logic               i_coarse,
    input  wire logic [19:0]        i_post_index,
    input  wire logic signed [15:0] i_post_height,
    input  wire logic signed [24:0] i_latitude,
    input  wire logic signed [24:0] i_longitude,
    output logic                    o_hold,
    output ggbl_pkg::t_mem_cmd      o_cmd,
    output ggbl_pkg::t_tag          o_tag
);
    import ggbl_pkg::*;

    logic signed [25:0] lat_x, lon_x, wl_x, oy_s;
    logic [26:0]        ox_x;
    logic [25:0]        oy_x;
    logic [2:0]         st_x;

    logic [10:0] cols;
    logic [9:0]  rows;

    // stage 1
    logic               r_p1_valid, r_p1_query, r_p1_wr_ok;
    logic [2:0]         r_p1_status;
    logic [26:0]        r_p1_ox;
    logic [25:0]        r_p1_oy;
    logic [19:0]        r_p1_index;
    logic signed [15:0] r_p1_height;

    // stage 2
    logic [10:0] px_x;
    logic [9:0]  py_x;
    logic        px_clamp, py_clamp;
    logic               r_p2_valid, r_p2_query, r_p2_wr_ok;
    logic [2:0]         r_p2_status;
    logic [10:0]        r_p2_px;
    logic [9:0]         r_p2_py;
    logic [16:0]        r_p2_dx, r_p2_dy;
    logic [19:0]        r_p2_index;
    logic signed [15:0] r_p2_height;

    // stage 3
    logic [ADDR_W-1:0]  base_x;
    logic               r_p3_valid, r_p3_query, r_p3_wr_ok;
    logic [2:0]         r_p3_status;
    logic [16:0]        r_p3_dx, r_p3_dy;
    logic [ADDR_W-1:0]  r_p3_a_n, r_p3_a_s;
    logic signed [15:0] r_p3_height;

    // issue stage
    logic               r_m_valid, r_m_query, r_m_wr_ok, r_m_phase;
    logic [2:0]         r_m_status;
    logic [16:0]        r_m_dx, r_m_dy;
    logic [ADDR_W-1:0]  r_m_a_n, r_m_a_s;
    logic signed [15:0] r_m_height;

    assign cols = i_coarse ? COARSE_COLS : GRID_COLS;
    assign rows = i_coarse ? COARSE_ROWS : GRID_ROWS;

    always_comb begin
        lat_x = 26'(i_latitude);
        lon_x = 26'(i_longitude);
        st_x  = ST_OK;
        if (!i_loaded) begin
            st_x = ST_NOT_LOADED;
        end else begin
            if (lat_x < -DEG_90 || lat_x > DEG_90) begin
                st_x = st_x | ST_LAT_BAD;
            end
            if (lon_x < -DEG_180 || lon_x > DEG_180) begin
                st_x = st_x | ST_LON_BAD;
            end
        end
        // west longitudes wrap into 180..360
        wl_x = lon_x[25] ? lon_x + DEG_360 : lon_x;
        ox_x = i_coarse ? {1'b0, wl_x[24:0], 1'b0} : {wl_x[24:0], 2'b00};
        oy_s = DEG_90 - lat_x;
        oy_x = i_coarse ? {1'b0, oy_s[23:0], 1'b0} : {oy_s[23:0], 2'b00};
    end

    assign o_hold = r_m_valid && r_m_query && !r_m_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (!o_hold) begin
            r_p1_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_hold) begin
            r_p1_query  <= i_query;
            r_p1_wr_ok  <= i_wr_ok;
            r_p1_status <= st_x;
            r_p1_ox     <= ox_x;
            r_p1_oy     <= oy_x;
            r_p1_index  <= i_post_index;
            r_p1_height <= i_post_height;
        end
    end

    // keep the post pair inside the grid at the east and south edges
    always_comb begin
        px_x     = r_p1_ox[26:16];
        py_x     = r_p1_oy[25:16];
        px_clamp = (px_x == cols - 11'd1);
        py_clamp = (py_x == rows - 10'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else if (!o_hold) begin
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_hold) begin
            r_p2_query  <= r_p1_query;
            r_p2_wr_ok  <= r_p1_wr_ok;
            r_p2_status <= r_p1_status;
            r_p2_px     <= px_clamp ? px_x - 11'd1 : px_x;
            r_p2_py     <= py_clamp ? py_x - 10'd1 : py_x;
            r_p2_dx     <= {1'b0, r_p1_ox[15:0]} + (px_clamp ? 17'h10000 : 17'h0);
            r_p2_dy     <= {1'b0, r_p1_oy[15:0]} + (py_clamp ? 17'h10000 : 17'h0);
            r_p2_index  <= r_p1_index;
            r_p2_height <= r_p1_height;
        end
    end

    assign base_x = r_p2_py * cols + ADDR_W'(r_p2_px);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_valid <= 1'b0;
        end else if (!o_hold) begin
            r_p3_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_hold) begin
            r_p3_query  <= r_p2_query;
            r_p3_wr_ok  <= r_p2_wr_ok;
            r_p3_status <= r_p2_status;
            r_p3_dx     <= r_p2_dx;
            r_p3_dy     <= r_p2_dy;
            r_p3_a_n    <= r_p2_query ? base_x : ADDR_W'(r_p2_index);
            r_p3_a_s    <= base_x + ADDR_W'(cols);
            r_p3_height <= r_p2_height;
        end
    end

    // a query holds the pipeline here to issue the north pair, then the south pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_m_phase <= 1'b0;
        end else if (o_hold) begin
            r_m_phase <= 1'b1;
        end else begin
            r_m_valid <= r_p3_valid;
            r_m_phase <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_hold) begin
            r_m_query  <= r_p3_query;
            r_m_wr_ok  <= r_p3_wr_ok;
            r_m_status <= r_p3_status;
            r_m_dx     <= r_p3_dx;
            r_m_dy     <= r_p3_dy;
            r_m_a_n    <= r_p3_a_n;
            r_m_a_s    <= r_p3_a_s;
            r_m_height <= r_p3_height;
        end
    end

    always_comb begin
        o_cmd.we     = r_m_valid && !r_m_query && r_m_wr_ok;
        o_cmd.re     = r_m_valid && r_m_query;
        o_cmd.addr_a = r_m_phase ? r_m_a_s : r_m_a_n;
        o_cmd.addr_b = o_cmd.addr_a + ADDR_W'(1);
        o_cmd.wdata  = r_m_height;
        o_tag.valid  = r_m_valid && r_m_query;
        o_tag.second = r_m_phase;
        o_tag.status = r_m_status;
        o_tag.dx     = r_m_dx;
        o_tag.dy     = r_m_dy;
    end

endmodule
`default_nettype wire

### sv/ggbl_post_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ggbl_post_mem
// height post store, one write/read port and one read port
// ----------------------------------------------------------------------------
module ggbl_post_mem #(
    parameter int STORE_DEPTH = 1048576
) (
    input  wire logic               i_clk,
    input  wire ggbl_pkg::t_mem_cmd i_cmd,
    output logic signed [15:0]      o_rd_a,
    output logic signed [15:0]      o_rd_b
);
    import ggbl_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);

    logic signed [15:0] r_mem [STORE_DEPTH];
    logic signed [15:0] r_rd_a, r_rd_b;
    logic [AW-1:0]      addr_a, addr_b;

    assign addr_a = AW'(i_cmd.addr_a);
    assign addr_b = AW'(i_cmd.addr_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[addr_a] <= i_cmd.wdata;
        end
        if (i_cmd.re) begin
            r_rd_a <= r_mem[addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.re) begin
            r_rd_b <= r_mem[addr_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule
`default_nettype wire

### sv/ggbl_blend.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ggbl_blend
// bilinear blend of four posts, meters to feet, rounding and saturation
// ----------------------------------------------------------------------------
module ggbl_blend (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ggbl_pkg::t_tag     i_tag,
    input  wire logic signed [15:0] i_rd_a,
    input  wire logic signed [15:0] i_rd_b,
    output logic                    o_push,
    output ggbl_pkg::t_result       o_result
);
    import ggbl_pkg::*;

    // 1250/381 feet per meter, result scaled from 2^-40 m to 2^-8 ft
    localparam logic [63:0] FEET_NUM   = 64'd1250;
    localparam logic [63:0] HALF_DEN   = 64'd381 << 31;
    localparam logic [25:0] T_SAT      = 26'd49938813;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << 35) + 64'd380) / 64'd381;
    localparam logic [26:0] RECIP      = 27'(RECIP_FULL);
    localparam logic [17:0] POS_MAX    = 18'h1FFFF;
    localparam logic [17:0] NEG_MAG    = 18'h20000;

    t_tag               r_r_tag;
    logic signed [15:0] r_nw, r_ne;

    logic signed [16:0] dn_x, ds_x;
    logic signed [17:0] dx_s;
    logic signed [33:0] u_x, l_x;
    logic               r_b1_valid;
    logic [2:0]         r_b1_status;
    logic [16:0]        r_b1_dy;
    logic signed [33:0] r_b1_u, r_b1_l;

    logic signed [34:0] du_x;
    logic signed [17:0] dy_s;
    logic signed [51:0] r_x;
    logic               r_b2_valid;
    logic [2:0]         r_b2_status;
    logic signed [51:0] r_b2_r;

    logic               r_c1_valid, r_c1_neg;
    logic [2:0]         r_c1_status;
    logic [50:0]        r_c1_mag;

    logic [63:0]        x_x;
    logic [31:0]        t_x;
    logic               r_c2_valid, r_c2_neg;
    logic [2:0]         r_c2_status;
    logic [25:0]        r_c2_t;

    logic [52:0]        qp_x;
    logic [17:0]        q_x;
    logic [17:0]        h_x;
    logic               r_c3_valid;
    t_result            r_c3_result;

    // read data stage; north pair is parked until the south pair lands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_tag <= '0;
        end else begin
            r_r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_r_tag.valid && !r_r_tag.second) begin
            r_nw <= i_rd_a;
            r_ne <= i_rd_b;
        end
    end

    // east-west blend of both rows
    always_comb begin
        dx_s = signed'({1'b0, r_r_tag.dx});
        dn_x = 17'(r_ne) - 17'(r_nw);
        ds_x = 17'(i_rd_b) - 17'(i_rd_a);
        u_x  = (34'(r_nw) <<< 16) + dn_x * dx_s;
        l_x  = (34'(i_rd_a) <<< 16) + ds_x * dx_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else begin
            r_b1_valid <= r_r_tag.valid && r_r_tag.second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1_status <= r_r_tag.status;
        r_b1_dy     <= r_r_tag.dy;
        r_b1_u      <= u_x;
        r_b1_l      <= l_x;
    end

    // north-south blend runs from the south row by the southward fraction
    always_comb begin
        dy_s = signed'({1'b0, r_b1_dy});
        du_x = 35'(r_b1_u) - 35'(r_b1_l);
        r_x  = (52'(r_b1_l) <<< 16) + du_x * dy_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_valid <= 1'b0;
            r_c1_valid <= 1'b0;
            r_c2_valid <= 1'b0;
            r_c3_valid <= 1'b0;
        end else begin
            r_b2_valid <= r_b1_valid;
            r_c1_valid <= r_b2_valid;
            r_c2_valid <= r_c1_valid;
            r_c3_valid <= r_c2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b2_status <= r_b1_status;
        r_b2_r      <= r_x;
    end

    // sign and magnitude
    always_ff @(posedge i_clk) begin
        r_c1_status <= r_b2_status;
        r_c1_neg    <= r_b2_r[51];
        r_c1_mag    <= 51'(r_b2_r[51] ? -r_b2_r : r_b2_r);
    end

    // scale by 1250 with half of the divisor added, drop 32 bits, clip
    always_comb begin
        x_x = r_c1_mag * FEET_NUM + HALF_DEN;
        t_x = x_x[63:32];
    end

    always_ff @(posedge i_clk) begin
        r_c2_status <= r_c1_status;
        r_c2_neg    <= r_c1_neg;
        r_c2_t      <= (t_x > 32'(T_SAT)) ? T_SAT : t_x[25:0];
    end

    // divide by 381 through the reciprocal, then saturate; a bad status gives height zero
    always_comb begin
        qp_x = 53'(r_c2_t) * 53'(RECIP);
        q_x  = qp_x[52:35];
        if (r_c2_status != ST_OK) begin
            h_x = '0;
        end else if (r_c2_neg) begin
            h_x = (q_x > NEG_MAG) ? NEG_MAG : 18'd0 - q_x;
        end else begin
            h_x = (q_x > POS_MAX) ? POS_MAX : q_x;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c3_result.status <= r_c2_status;
        r_c3_result.height <= signed'(h_x);
    end

    assign o_push   = r_c3_valid;
    assign o_result = r_c3_result;

endmodule
`default_nettype wire

### sv/ggbl_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ggbl_out_fifo
// result queue between the pipeline and the output stream
// ----------------------------------------------------------------------------
module ggbl_out_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ggbl_pkg::t_result i_data,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output ggbl_pkg::t_result      o_data
);
    import ggbl_pkg::*;

    t_result             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + FIFO_CW'(1);
                2'b01:   r_count <= r_count - FIFO_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule
`default_nettype wire

### sv/geoid_grid_bilinear_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// geoid_grid_bilinear_lookup
// geoid height grid store with bilinear lookup in feet
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser selects the beat kind. A load beat writes one
// height post at its row-major index; writing the last post of the grid that
// the datum selects marks the grid loaded. A query beat gives latitude and
// longitude and returns one result beat on m_axis: height in feet and status.
// Config channel (i_cfg_*): datum code, always ready; a change of datum marks
// the grid unloaded. Write it only while no query is outstanding.
// Loads stream without holding the input; a query holds it while its four posts
// come from the two read ports of the post store, north pair then south pair.
// Reset clears the loaded flag, sets datum 1996 and empties the pipeline; the
// post store itself is not cleared and must be loaded before queries.
// Back pressure: results go into an 8-deep queue; up to 8 queries may be
// outstanding, and while the receiver stalls input is still taken until that
// many queries are outstanding.
// ----------------------------------------------------------------------------
module geoid_grid_bilinear_lookup #(
    parameter int STORE_DEPTH = 1048576
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_data,    // datum
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [87:0] s_axis_tdata,  // post_index, post_height, latitude, longitude
    input  wire logic [0:0]  s_axis_tuser,  // mode
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata   // height_feet, status
);
    import ggbl_pkg::*;

    // unpacked input fields
    logic [19:0]        post_index;
    logic signed [15:0] post_height;
    logic signed [24:0] latitude, longitude;

    logic [1:0]         r_datum;
    logic               r_loaded;
    logic [FIFO_CW-1:0] r_credits;

    logic     coarse, accept, q_accept, pop, wr_ok, hold, cfg_wr;
    logic     push;
    t_mem_cmd cmd;
    t_tag     tag;
    t_result  res_in, res_out;
    logic signed [15:0] rd_a, rd_b;

    assign post_index  = s_axis_tdata[19:0];
    assign post_height = signed'(s_axis_tdata[35:20]);
    assign latitude    = signed'(s_axis_tdata[60:36]);
    assign longitude   = signed'(s_axis_tdata[85:61]);

    assign coarse = (r_datum == DATUM_1984);

    // a credit per outstanding query keeps the result queue from overflowing
    assign s_axis_tready = !hold && (r_credits != FIFO_CW'(FIFO_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign q_accept      = accept && (s_axis_tuser[0] == MODE_QUERY);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign wr_ok         = (32'(post_index) < 32'(STORE_DEPTH));

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_datum  <= DATUM_1996;
            r_loaded <= 1'b0;
        end else if (cfg_wr) begin
            r_datum <= i_cfg_data;
            if (i_cfg_data != r_datum) begin
                r_loaded <= 1'b0;
            end
        end else if (accept && (s_axis_tuser[0] != MODE_QUERY) && wr_ok) begin
            // last post of the selected grid completes the load
            if (post_index == (coarse ? LAST_POST_COARSE : LAST_POST_GRID)) begin
                r_loaded <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credits <= '0;
        end else begin
            r_credits <= r_credits + FIFO_CW'(q_accept) - FIFO_CW'(pop);
        end
    end

    ggbl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_query       (s_axis_tuser[0] == MODE_QUERY),
        .i_wr_ok       (wr_ok),
        .i_loaded      (r_loaded),
        .i_coarse      (coarse),
        .i_post_index  (post_index),
        .i_post_height (post_height),
        .i_latitude    (latitude),
        .i_longitude   (longitude),
        .o_hold        (hold),
        .o_cmd         (cmd),
        .o_tag         (tag)
    );

    ggbl_post_mem #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_post_mem (
        .i_clk  (i_clk),
        .i_cmd  (cmd),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    ggbl_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (tag),
        .i_rd_a   (rd_a),
        .i_rd_b   (rd_b),
        .o_push   (push),
        .o_result (res_in)
    );

    ggbl_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_valid (m_axis_tvalid),
        .o_data  (res_out)
    );

    assign m_axis_tdata = {3'b000, res_out.status, res_out.height};

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credits <= FIFO_CW'(FIFO_DEPTH))
        else $error("credit count above queue depth");

    a_result_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_credits != '0))
        else $error("result waiting without an outstanding query");

    a_datum_unloads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && (i_cfg_data != r_datum)) |=> !r_loaded)
        else $error("datum change left grid marked loaded");
`endif

endmodule
`default_nettype wire

### bench/ggbl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggbl_checker
// watches the config, input and result channels of the geoid lookup, keeps
// its own copy of the post store, datum and loaded flag, and compares every
// result beat against the predicted height and status in arrival order
// ----------------------------------------------------------------------------
module ggbl_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_data,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [87:0] i_s_tdata,
    input  wire logic [0:0]  i_s_tuser,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [23:0] i_m_tdata,
    output int               o_errors,
    output int               o_pending
);
    import ggbl_pkg::*;

    localparam longint ONE_DEG = 65536;

    typedef struct {
        logic [17:0] feet;
        logic [2:0]  status;
    } t_height_result;

    shortint        post_store [int];
    logic [1:0]     datum_q;
    bit             grid_ok;
    t_height_result expected_heights [$];
    int             err_cnt;

    assign o_errors  = err_cnt;
    assign o_pending = expected_heights.size();

    function automatic longint post_at(longint i);
        return post_store.exists(int'(i)) ? longint'(post_store[int'(i)]) : 0;
    endfunction

    // bilinear blend of the four posts around the position, meters to feet
    function automatic t_height_result lookup_height(logic [24:0] la_raw, logic [24:0] lo_raw);
        t_height_result res;
        longint lat, lon, wl, rows, cols, ox, oy, px, py, dx, dy, b;
        longint nw, ne, sw, se, u, l, r;
        longint unsigned mag, den, q;
        int shift;
        bit neg;
        res.feet = '0;
        res.status = ST_OK;
        if (!grid_ok) begin
            res.status = ST_NOT_LOADED;
            return res;
        end
        lat = longint'($signed(la_raw));
        lon = longint'($signed(lo_raw));
        if (lat < -90 * ONE_DEG || lat > 90 * ONE_DEG) res.status |= ST_LAT_BAD;
        if (lon < -180 * ONE_DEG || lon > 180 * ONE_DEG) res.status |= ST_LON_BAD;
        if (res.status != ST_OK) return res;
        rows  = (datum_q == DATUM_1984) ? 361 : 721;
        cols  = (datum_q == DATUM_1984) ? 721 : 1441;
        shift = (datum_q == DATUM_1984) ? 1 : 2;
        wl = (lon < 0) ? lon + 360 * ONE_DEG : lon;
        ox = wl <<< shift;
        oy = (90 * ONE_DEG - lat) <<< shift;
        px = ox >>> 16;
        if (px + 1 == cols) px--;
        py = oy >>> 16;
        if (py + 1 == rows) py--;
        dx = ox - (px <<< 16);
        dy = oy - (py <<< 16);
        b  = py * cols + px;
        nw = post_at(b);
        ne = post_at(b + 1);
        sw = post_at(b + cols);
        se = post_at(b + cols + 1);
        u = nw * 65536 + dx * (ne - nw);
        l = sw * 65536 + dx * (se - sw);
        // southern row toward northern row by the southward fraction
        r = l * 65536 + dy * (u - l);
        neg = r < 0;
        mag = neg ? longint'(0) - r : r;
        den = longint'(381) <<< 32;
        q = (mag * 1250 + den / 2) / den;
        if (neg) begin
            if (q > 131072) q = 131072;
            res.feet = 18'(-q);
        end else begin
            if (q > 131071) q = 131071;
            res.feet = 18'(q);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        t_height_result exp_r;
        logic [19:0] idx;
        if (!i_rst_n) begin
            datum_q <= DATUM_1996;
            grid_ok <= 1'b0;
            expected_heights.delete();
            err_cnt <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_data != datum_q) grid_ok <= 1'b0;
                datum_q <= i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == MODE_LOAD) begin
                    idx = i_s_tdata[19:0];
                    post_store[int'(idx)] = shortint'(i_s_tdata[35:20]);
                    if (idx == ((datum_q == DATUM_1984) ? LAST_POST_COARSE : LAST_POST_GRID))
                        grid_ok <= 1'b1;
                end else begin
                    expected_heights.push_back(lookup_height(i_s_tdata[60:36],
                                                             i_s_tdata[85:61]));
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_heights.size() == 0) begin
                    $display("%0t: result beat with none expected: feet %h status %0d",
                             $time, i_m_tdata[17:0], i_m_tdata[20:18]);
                    err_cnt <= err_cnt + 1;
                end else begin
                    exp_r = expected_heights.pop_front();
                    if (exp_r.feet !== i_m_tdata[17:0] || exp_r.status !== i_m_tdata[20:18]) begin
                        $display("%0t: mismatch expected feet %h status %0d, got feet %h status %0d",
                                 $time, exp_r.feet, exp_r.status,
                                 i_m_tdata[17:0], i_m_tdata[20:18]);
                        err_cnt <= err_cnt + 1;
                    end
                end
            end
        end
    end

endmodule

### bench/tb_geoid_grid_bilinear_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_geoid_grid_bilinear_lookup
// drives load and query beats into the geoid lookup under several datums and
// random flow control; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module tb_geoid_grid_bilinear_lookup;
    import ggbl_pkg::*;

    localparam int ONE_DEG     = 65536;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;

    // height choices for the four posts of a cell
    typedef enum int { H_RAND, H_MIN, H_MAX } t_hsel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_data = DATUM_1996;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;   // post_index, post_height, latitude, longitude
    logic [0:0]  s_axis_tuser = '0;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // height_feet, status

    int   fail_cnt, pending_cnt;
    int   tx_idle = 0, rx_idle = 0;
    bit   hold_req = 1'b0, hold_done = 1'b0;
    int   hold_left = 0;
    int   cycle_cnt = 0;
    int   beats;
    logic [1:0] cur_datum = DATUM_1996;

    always #5 i_clk = ~i_clk;

    geoid_grid_bilinear_lookup dut (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
    );

    ggbl_checker u_checker (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_data,
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata),
        .o_errors(fail_cnt), .o_pending(pending_cnt)
    );

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // one input beat, with an optional gap in front
    task automatic send_beat(input bit mode, input logic [19:0] idx, input logic [15:0] h,
                             input logic [24:0] la, input logic [24:0] lo);
        if ($urandom_range(99) < tx_idle) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, lo, la, h, idx};
        s_axis_tuser  <= mode;
        beats++;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic load_post(input logic [19:0] idx, input logic [15:0] h);
        send_beat(MODE_LOAD, idx, h, 25'($urandom), 25'($urandom));
    endtask

    task automatic query(input logic [24:0] la, input logic [24:0] lo);
        send_beat(MODE_QUERY, 20'($urandom), 16'($urandom), la, lo);
    endtask

    // loads the four posts around an in-range position, then queries it
    task automatic query_cell(input int la, input int lo, input t_hsel hsel);
        int rows, cols, shift, wl, px, py, b;
        logic [15:0] h;
        rows  = (cur_datum == DATUM_1984) ? 361 : 721;
        cols  = (cur_datum == DATUM_1984) ? 721 : 1441;
        shift = (cur_datum == DATUM_1984) ? 1 : 2;
        wl = (lo < 0) ? lo + 360 * ONE_DEG : lo;
        px = (wl <<< shift) >>> 16;
        if (px + 1 == cols) px--;
        py = ((90 * ONE_DEG - la) <<< shift) >>> 16;
        if (py + 1 == rows) py--;
        b = py * cols + px;
        for (int k = 0; k < 4; k++) begin
            h = (hsel == H_MIN) ? 16'h8000 : (hsel == H_MAX) ? 16'h7fff : 16'($urandom);
            load_post(20'(b + (k / 2) * cols + (k % 2)), h);
        end
        query(25'(la), 25'(lo));
    endtask

    task automatic rand_cell_query();
        query_cell(int'($urandom_range(0, 180 * ONE_DEG)) - 90 * ONE_DEG,
                   int'($urandom_range(0, 360 * ONE_DEG)) - 180 * ONE_DEG, H_RAND);
    endtask

    // out-of-range position; the result ignores the posts
    task automatic bad_query();
        int la, lo;
        la = int'($signed(25'($urandom)));
        lo = int'($signed(25'($urandom)));
        if (la >= -90 * ONE_DEG && la <= 90 * ONE_DEG &&
            lo >= -180 * ONE_DEG && lo <= 180 * ONE_DEG)
            la = 90 * ONE_DEG + 1 + int'($urandom_range(0, 8 * ONE_DEG));
        query(25'(la), 25'(lo));
    endtask

    task automatic load_last_post();
        load_post((cur_datum == DATUM_1984) ? LAST_POST_COARSE : LAST_POST_GRID, 16'($urandom));
    endtask

    // datum write once the block has drained
    task automatic write_datum(input logic [1:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_datum = v;
    endtask

    initial begin
        logic [1:0] phase_datum [6];
        int r, target;
        phase_datum = '{DATUM_1984, DATUM_1984, DATUM_2008, DATUM_SPARE, DATUM_1996,
                        DATUM_2008};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: not loaded first, then range errors and grid corners
        query(25'd0, 25'd0);
        load_last_post();
        query(25'h0ffffff, 25'd0);
        query(25'h1000000, 25'd0);
        query(25'd0, 25'(180 * ONE_DEG + 1));
        query(25'h1000000, 25'h1000000);
        query(25'h0ffffff, 25'h0ffffff);
        query_cell(90 * ONE_DEG, 0, H_MAX);
        query_cell(-90 * ONE_DEG, 180 * ONE_DEG, H_MIN);
        query_cell(-90 * ONE_DEG, -180 * ONE_DEG, H_RAND);
        query_cell(0, -1, H_MAX);
        query_cell(45 * ONE_DEG + 32768, 90 * ONE_DEG + 16384, H_MIN);
        // beyond the grid but inside the store
        load_post(20'hfffff, 16'h8000);
        load_post(20'hfffff, 16'h7fff);

        beats = 0;
        for (int p = 0; p < 6; p++) begin
            tx_idle = (p < 2) ? 8 : (p < 4) ? 80 : 0;
            rx_idle = (p < 2) ? 80 : (p < 4) ? 8 : 0;
            if (phase_datum[p] != cur_datum) begin
                write_datum(phase_datum[p]);
                // a datum change leaves the grid unloaded
                query(25'($urandom), 25'($urandom));
                load_last_post();
            end else begin
                write_datum(phase_datum[p]);
            end
            if (p == 4) hold_req <= 1'b1;
            target = beats + 125;
            while (beats < target) begin
                r = $urandom_range(99);
                if (r < 70) rand_cell_query();
                else if (r < 82) bad_query();
                else load_post(20'($urandom), 16'($urandom));
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### sim.f
sv/ggbl_pkg.sv
sv/ggbl_front.sv
sv/ggbl_post_mem.sv
sv/ggbl_blend.sv
sv/ggbl_out_fifo.sv
sv/geoid_grid_bilinear_lookup.sv
bench/ggbl_checker.sv
bench/tb_geoid_grid_bilinear_lookup.sv
